FILE: rtl/tlbp_pkg.sv
// Shared types and constants for the two-level branch predictor with BTB.
`default_nettype none

package tlbp_pkg;

    localparam int unsigned DEF_BTB_DEPTH          = 32;
    localparam int unsigned DEF_COUNTERS_PER_TABLE = 256;
    localparam int unsigned DEF_MAX_HISTORY        = 8;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned WORD_W  = 30;
    localparam int unsigned CTR_MAX = 3;
    localparam int unsigned PC_STEP = 4;
    localparam int unsigned HI_SHARE_LSB = 16;
    localparam int unsigned LO_SHARE_LSB = 2;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] target_pc;
        logic              taken;
        logic [ADDR_W-1:0] predicted_target;
    } t_in;

    typedef struct packed {
        logic              predict_taken;
        logic [ADDR_W-1:0] predicted_dest;
        logic [ADDR_W-1:0] branch_count;
        logic [ADDR_W-1:0] flush_count;
    } t_out;

    typedef enum logic [2:0] {
        CFG_BTB_LOG2  = 3'd0,
        CFG_HIST_BITS = 3'd1,
        CFG_TAG_BITS  = 3'd2,
        CFG_FSM_INIT  = 3'd3,
        CFG_GHIST     = 3'd4,
        CFG_GTABLE    = 3'd5,
        CFG_SHARE     = 3'd6,
        CFG_NONE      = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SHARE_NONE = 2'd0,
        SHARE_LOW  = 2'd1,
        SHARE_HIGH = 2'd2,
        SHARE_ALT  = 2'd3
    } t_share;

    localparam logic ACT_PREDICT = 1'b0;
    localparam logic ACT_UPDATE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDX,
        ST_SEL,
        ST_RD,
        ST_CALC,
        ST_CLR,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/two_level_branch_predictor_btb_core.sv
// Top level of the two-level branch predictor with a direct-mapped BTB.
`default_nettype none

// The block handles one beat at a time under a small sequencer: entry index, counter
// select, counter memory read, evaluate, result. A predict beat and an update beat that
// needs no refill go through just these steps before the next acceptance. An update
// that has to refill a counter table (a tag miss with per-entry tables, or the first
// training of a table since reset or a register write) walks that table through the
// single write port of the counter memory, one write per reachable counter:
// 2^h, where h is history_bits clamped to 1..MAX_HISTORY, but at most
// COUNTERS_PER_TABLE. A result that waits on a stalled output holds the sequencer in its
// result step and so delays the next acceptance. Tables carry a valid bit each, so
// there is no clearing pass after reset or after a register write. A register write to
// any index other than CFG_NONE re-initializes all predictor state, and registers are
// to be written only while the block is idle.
module two_level_branch_predictor_btb_core
    import tlbp_pkg::*;
#(
    parameter int unsigned BTB_DEPTH          = DEF_BTB_DEPTH,
    parameter int unsigned COUNTERS_PER_TABLE = DEF_COUNTERS_PER_TABLE,
    parameter int unsigned MAX_HISTORY        = DEF_MAX_HISTORY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire t_in         i_in_data,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      t_out        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int unsigned EW        = (BTB_DEPTH > 1) ? $clog2(BTB_DEPTH) : 1;
    localparam int unsigned CW        = $clog2(COUNTERS_PER_TABLE);
    localparam int unsigned MEM_DEPTH = BTB_DEPTH * COUNTERS_PER_TABLE;
    localparam int unsigned AW        = $clog2(MEM_DEPTH);
    localparam int unsigned HW        = MAX_HISTORY;

    // Configuration registers.
    logic [2:0] r_btb_log2;
    logic [3:0] r_hist_bits;
    logic [4:0] r_tag_bits;
    logic [1:0] r_fsm_init;
    logic       r_ghist;
    logic       r_gtable;
    logic [1:0] r_share;

    logic     cfg_wr;
    logic     cfg_init;
    t_cfg_idx cfg_idx;

    // Sequencer and item registers.
    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_res;
    t_out   r_out;
    logic   r_out_valid;
    logic   out_free;

    logic [EW-1:0]     r_e;
    logic [WORD_W-1:0] r_tag;
    logic [EW-1:0]     r_hs;
    logic [EW-1:0]     r_row;
    logic [HW-1:0]     r_sel;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_base;
    logic [CW-1:0]     r_j;
    logic              r_train;
    logic [1:0]        r_newctr;

    // Predictor state.
    logic [WORD_W-1:0] r_tags [BTB_DEPTH];
    logic [WORD_W-1:0] r_tgts [BTB_DEPTH];
    logic [HW-1:0]     r_hist [BTB_DEPTH];
    logic [BTB_DEPTH-1:0] r_row_vld;
    logic              r_last_pred;
    logic [31:0]       r_branches;
    logic [31:0]       r_flushes;

    // Counter memory.
    logic [1:0]    mem [MEM_DEPTH];
    logic [1:0]    r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;
    logic [AW-1:0] rd_addr;

    // Derived configuration values.
    logic [3:0]        hlen;
    logic [HW-1:0]     hmask;
    logic [6:0]        btb_mask;
    logic [WORD_W-1:0] tag_mask;
    logic [CW-1:0]     sweep_last;

    // Evaluation signals.
    logic [WORD_W-1:0] word;
    logic [HW-1:0]     hcur;
    logic [HW-1:0]     pc_bits;
    logic [EW-1:0]     hs_sel;
    logic              hit;
    logic              local_miss;
    logic              need_clr;
    logic [1:0]        ctr;
    logic [1:0]        ctr_trained;
    logic              ptaken;
    logic              flush;
    logic [31:0]       branches_nx;
    logic [31:0]       flushes_nx;
    logic              sweep_done;

    // Remainder by BTB_DEPTH of a 7-bit value by restoring subtraction.
    function automatic logic [EW-1:0] mod_btb(input logic [6:0] x);
        logic [13:0] r;
        r = 14'(x);
        for (int k = 6; k >= 0; k--) begin
            if (r >= (14'(BTB_DEPTH) << k)) begin
                r = r - (14'(BTB_DEPTH) << k);
            end
        end
        return EW'(r);
    endfunction

    // Remainder by COUNTERS_PER_TABLE of a history-wide value.
    function automatic logic [CW-1:0] mod_cpt(input logic [HW-1:0] x);
        logic [HW+9:0] r;
        r = (HW+10)'(x);
        for (int k = HW - 1; k >= 0; k--) begin
            if (r >= ((HW+10)'(COUNTERS_PER_TABLE) << k)) begin
                r = r - ((HW+10)'(COUNTERS_PER_TABLE) << k);
            end
        end
        return CW'(r);
    endfunction

    // ---------------------------------------------------------------- configuration
    assign pready  = 1'b1;
    assign cfg_idx = t_cfg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_init = cfg_wr && (cfg_idx != CFG_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btb_log2  <= 3'd0;
            r_hist_bits <= 4'd1;
            r_tag_bits  <= 5'd0;
            r_fsm_init  <= 2'd1;
            r_ghist     <= 1'b0;
            r_gtable    <= 1'b0;
            r_share     <= 2'd0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_BTB_LOG2:  r_btb_log2  <= pwdata[2:0];
                CFG_HIST_BITS: r_hist_bits <= pwdata[3:0];
                CFG_TAG_BITS:  r_tag_bits  <= pwdata[4:0];
                CFG_FSM_INIT:  r_fsm_init  <= pwdata[1:0];
                CFG_GHIST:     r_ghist     <= pwdata[0];
                CFG_GTABLE:    r_gtable    <= pwdata[0];
                CFG_SHARE:     r_share     <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_BTB_LOG2:  prdata = {29'd0, r_btb_log2};
            CFG_HIST_BITS: prdata = {28'd0, r_hist_bits};
            CFG_TAG_BITS:  prdata = {27'd0, r_tag_bits};
            CFG_FSM_INIT:  prdata = {30'd0, r_fsm_init};
            CFG_GHIST:     prdata = {31'd0, r_ghist};
            CFG_GTABLE:    prdata = {31'd0, r_gtable};
            CFG_SHARE:     prdata = {30'd0, r_share};
            default:       prdata = 32'd0;
        endcase
    end

    // History length is clamped to 1..MAX_HISTORY.
    always_comb begin
        if (r_hist_bits == 4'd0) begin
            hlen = 4'd1;
        end else if (32'(r_hist_bits) > MAX_HISTORY) begin
            hlen = 4'(MAX_HISTORY);
        end else begin
            hlen = r_hist_bits;
        end
        for (int i = 0; i < HW; i++) begin
            hmask[i] = (i < 32'(hlen));
        end
        for (int i = 0; i < 7; i++) begin
            btb_mask[i] = (i < 32'(r_btb_log2));
        end
        for (int i = 0; i < WORD_W; i++) begin
            tag_mask[i] = (i < 32'(r_tag_bits));
        end
        // Only the first min(2^h, table size) counters of a table are reachable.
        if ((HW+1)'(hmask) >= (HW+1)'(COUNTERS_PER_TABLE - 1)) begin
            sweep_last = CW'(COUNTERS_PER_TABLE - 1);
        end else begin
            sweep_last = CW'(hmask);
        end
    end

    // ---------------------------------------------------------------- datapath helpers
    assign word    = r_in.pc[ADDR_W-1:LO_SHARE_LSB];
    assign hs_sel  = r_ghist ? EW'(0) : r_e;
    assign hcur    = r_hist[hs_sel] & hmask;

    always_comb begin
        case (t_share'(r_share))
            SHARE_NONE: pc_bits = '0;
            SHARE_LOW:  pc_bits = r_in.pc[LO_SHARE_LSB +: HW];
            default:    pc_bits = r_in.pc[HI_SHARE_LSB +: HW];
        endcase
    end

    assign rd_addr = AW'(AW'(r_row) * AW'(COUNTERS_PER_TABLE)) + AW'(mod_cpt(r_sel));

    // An invalid table reads as the initial counter value.
    assign ctr        = r_row_vld[r_row] ? r_rdata : r_fsm_init;
    assign hit        = (r_tags[r_e] == r_tag);
    assign local_miss = !hit && !r_gtable;
    assign need_clr   = local_miss || !r_row_vld[r_row];
    assign ptaken     = hit && (ctr > 2'd1);

    always_comb begin
        if (r_in.taken) begin
            ctr_trained = (ctr == 2'(CTR_MAX)) ? ctr : ctr + 2'd1;
        end else begin
            ctr_trained = (ctr == 2'd0) ? ctr : ctr - 2'd1;
        end
    end

    assign flush = (r_last_pred != r_in.taken) ||
                   (r_last_pred && r_in.taken && (r_in.target_pc != r_in.predicted_target));
    assign branches_nx = r_branches + 32'd1;
    assign flushes_nx  = r_flushes + 32'(flush);
    assign sweep_done  = (r_j == sweep_last);
    assign out_free    = !r_out_valid || !i_out_stall;

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = ctr_trained;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_IDX;
                end
            end
            ST_IDX: n_state = ST_SEL;
            ST_SEL: n_state = ST_RD;
            ST_RD:  n_state = ST_CALC;
            ST_CALC: begin
                if (r_in.action == ACT_UPDATE && need_clr) begin
                    n_state = ST_CLR;
                end else begin
                    n_state = ST_FIN;
                    mem_we  = (r_in.action == ACT_UPDATE);
                end
            end
            ST_CLR: begin
                // The pending trained value lands in the sweep at its own slot.
                mem_we    = 1'b1;
                mem_waddr = r_base + AW'(r_j);
                mem_wdata = (r_train && (mem_waddr == r_addr)) ? r_newctr : r_fsm_init;
                if (sweep_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // ---------------------------------------------------------------- item registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: r_in <= i_in_data;
            ST_IDX: begin
                r_e   <= mod_btb(word[6:0] & btb_mask);
                r_tag <= word & tag_mask;
            end
            ST_SEL: begin
                r_hs  <= hs_sel;
                r_row <= r_gtable ? EW'(0) : r_e;
                r_sel <= (hcur ^ pc_bits) & hmask;
            end
            ST_RD: begin
                r_addr <= rd_addr;
                r_base <= AW'(AW'(r_row) * AW'(COUNTERS_PER_TABLE));
            end
            ST_CALC: begin
                r_j      <= '0;
                r_train  <= !local_miss;
                r_newctr <= ctr_trained;
                if (r_in.action == ACT_PREDICT) begin
                    r_res.predict_taken  <= ptaken;
                    r_res.predicted_dest <= ptaken ? {r_tgts[r_e], 2'b00}
                                                   : r_in.pc + 32'(PC_STEP);
                    r_res.branch_count   <= r_branches;
                    r_res.flush_count    <= r_flushes;
                end else begin
                    r_res.predict_taken  <= 1'b0;
                    r_res.predicted_dest <= '0;
                    r_res.branch_count   <= branches_nx;
                    r_res.flush_count    <= flushes_nx;
                end
            end
            ST_CLR: r_j <= r_j + CW'(1);
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- predictor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_init) begin
            for (int i = 0; i < BTB_DEPTH; i++) begin
                r_tags[i] <= '0;
                r_tgts[i] <= '0;
                r_hist[i] <= '0;
            end
            r_row_vld   <= '0;
            r_last_pred <= 1'b0;
            r_branches  <= '0;
            r_flushes   <= '0;
        end else begin
            if (r_state == ST_CALC) begin
                if (r_in.action == ACT_PREDICT) begin
                    r_last_pred <= ptaken;
                end else begin
                    r_tags[r_e] <= r_tag;
                    r_tgts[r_e] <= r_in.target_pc[ADDR_W-1:LO_SHARE_LSB];
                    if (!hit && !r_ghist) begin
                        r_hist[r_hs] <= '0;
                    end else begin
                        r_hist[r_hs] <= {r_hist[r_hs][HW-2:0], r_in.taken} & hmask;
                    end
                    r_branches <= branches_nx;
                    r_flushes  <= flushes_nx;
                end
            end
            if (r_state == ST_CLR && sweep_done) begin
                r_row_vld[r_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_IDX))
        else $error("accepted beat did not start the sequencer");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> (r_j <= sweep_last))
        else $error("table sweep ran past its last counter");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result beat appeared outside the result step");
`endif

endmodule

`default_nettype wire
